// File: hdl/assert_macros.svh
// Assertion helpers shared by the front-end and queue RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds on a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// File: hdl/sidlpd_pkg.sv
package sidlpd_pkg;

    // One result word as it travels from the parser to the output stage.
    typedef struct packed {
        logic [7:0] packet_id;
        logic [7:0] packet_length;
        logic [7:0] data_byte;
        logic [7:0] byte_pos;
        logic       is_last;
        logic       is_empty_packet;
        logic       is_abort;
    } t_result;

    localparam logic [7:0] SYNC_RESET  = 8'hA5;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         QUEUE_AW    = 2;

endpackage

// File: hdl/sidlpd_front.sv
`include "assert_macros.svh"

module sidlpd_front #(
    parameter int PAYLOAD_CAPACITY = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    input  logic                i_rx_valid,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_queue_full,
    output logic                o_rx_ready,
    output logic                o_push,
    output sidlpd_pkg::t_result o_push_word
);

    localparam int              CW  = $clog2(PAYLOAD_CAPACITY + 1);
    localparam logic [CW-1:0]   CAP = CW'(PAYLOAD_CAPACITY);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_DATA
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [7:0]      r_sync;
    logic [7:0]      r_id, n_id;
    logic [7:0]      r_len, n_len;
    logic [CW-1:0]   r_taken, n_taken;
    logic [CW-1:0]   w_taken_inc;
    logic            w_accept;

    assign o_rx_ready  = !i_queue_full;
    assign w_accept    = i_rx_valid && o_rx_ready;
    assign w_taken_inc = r_taken + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_id        = r_id;
        n_len       = r_len;
        n_taken     = r_taken;
        o_push      = 1'b0;
        o_push_word = '0;
        o_push_word.packet_id     = r_id;
        o_push_word.packet_length = r_len;
        if (w_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == r_sync) begin
                        n_phase = PH_ID;
                    end
                end
                PH_ID: begin
                    n_id    = i_rx_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_taken = '0;
                    if (i_rx_byte == 8'd0) begin
                        // empty packet: report it and drop back to hunting
                        o_push                      = 1'b1;
                        o_push_word.packet_length   = i_rx_byte;
                        o_push_word.is_last         = 1'b1;
                        o_push_word.is_empty_packet = 1'b1;
                        n_phase                     = PH_HUNT;
                        n_id                        = '0;
                        n_len                       = '0;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_push = 1'b1;
                    if (r_taken >= CAP) begin
                        // buffer overrun: drop the word and abort the packet
                        o_push_word.is_last  = 1'b1;
                        o_push_word.is_abort = 1'b1;
                        n_phase              = PH_HUNT;
                        n_taken              = '0;
                        n_id                 = '0;
                        n_len                = '0;
                    end else begin
                        o_push_word.data_byte  = i_rx_byte;
                        o_push_word.byte_pos   = 8'(r_taken);
                        o_push_word.is_last    = (9'(w_taken_inc) == {1'b0, r_len});
                        n_taken                = w_taken_inc;
                        if (o_push_word.is_last) begin
                            n_phase = PH_HUNT;
                            n_taken = '0;
                            n_id    = '0;
                            n_len   = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sync  <= sidlpd_pkg::SYNC_RESET;
            r_id    <= '0;
            r_len   <= '0;
            r_taken <= '0;
        end else begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_len   <= n_len;
            r_taken <= n_taken;
            if (i_cfg_wr_en) begin
                r_sync <= i_cfg_wr_data;
            end
        end
    end

    `ASSERT_CLK(a_end_hunts, i_clk, i_rst_n, (o_push && o_push_word.is_last) |=> r_phase == PH_HUNT, "end did not hunt")
    `ASSERT_CLK(a_push_phase, i_clk, i_rst_n, o_push |-> (r_phase == PH_LEN || r_phase == PH_DATA), "bad push phase")
    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, o_push && i_queue_full, "push while queue full")

endmodule

// File: hdl/sidlpd_queue.sv
`include "assert_macros.svh"

module sidlpd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sidlpd_pkg::t_result i_push_word,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output sidlpd_pkg::t_result o_word
);

    localparam int AW = sidlpd_pkg::QUEUE_AW;

    sidlpd_pkg::t_result r_mem [sidlpd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]       r_wr_ptr;
    logic [AW-1:0]       r_rd_ptr;
    logic [AW:0]         r_count;

    assign o_full  = (r_count == (AW+1)'(sidlpd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ASSERT_CLK(a_count_up, i_clk, i_rst_n, (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1, "queue count did not advance")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")

endmodule

// File: hdl/sidlpd_back.sv
module sidlpd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sidlpd_pkg::t_result i_word,
    output logic                o_pop,
    input  logic                i_pkt_ready,
    output logic                o_pkt_valid,
    output sidlpd_pkg::t_result o_word
);

    logic                r_valid;
    sidlpd_pkg::t_result r_word;

    // load when the output register is free or being drained this cycle
    assign o_pop       = i_valid && (!r_valid || i_pkt_ready);
    assign o_pkt_valid = r_valid;
    assign o_word      = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_pkt_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_word;
        end
    end

endmodule

// File: hdl/sync_id_length_packet_deframer_unit.sv
// Packet deframer: takes one received byte per cycle unless the queue is full,
// hunts for the sync byte (register, reset 0xA5), then reads an id byte and a
// length byte and streams each payload byte out at once with its id, length,
// index and last mark. A zero-length packet gives one empty-packet word; a
// payload byte beyond PAYLOAD_CAPACITY is dropped with an abort word and
// hunting resumes. The parser pushes each result into a four-entry queue; an
// output register drains the queue, so a result is held in a queue entry and
// then in the output register. Input stalls only when the queue is full under
// back-pressure. Write the sync register only while the block is idle.
module sync_id_length_packet_deframer_unit #(
    parameter int PAYLOAD_CAPACITY = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_pkt_valid,
    input  logic       i_pkt_ready,
    output logic [7:0] o_packet_id,
    output logic [7:0] o_packet_length,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_pos,
    output logic       o_is_last,
    output logic       o_is_empty_packet,
    output logic       o_is_abort
);

    logic                w_push;
    sidlpd_pkg::t_result w_push_word;
    logic                w_full;
    logic                w_q_valid;
    sidlpd_pkg::t_result w_q_word;
    logic                w_pop;
    sidlpd_pkg::t_result w_out_word;

    sidlpd_front #(
        .PAYLOAD_CAPACITY(PAYLOAD_CAPACITY)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx_valid    (i_rx_valid),
        .i_rx_byte     (i_rx_byte),
        .i_queue_full  (w_full),
        .o_rx_ready    (o_rx_ready),
        .o_push        (w_push),
        .o_push_word   (w_push_word)
    );

    sidlpd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_word (w_push_word),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_valid     (w_q_valid),
        .o_word      (w_q_word)
    );

    sidlpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_word      (w_q_word),
        .o_pop       (w_pop),
        .i_pkt_ready (i_pkt_ready),
        .o_pkt_valid (o_pkt_valid),
        .o_word      (w_out_word)
    );

    assign o_packet_id       = w_out_word.packet_id;
    assign o_packet_length   = w_out_word.packet_length;
    assign o_data_byte       = w_out_word.data_byte;
    assign o_byte_pos        = w_out_word.byte_pos;
    assign o_is_last         = w_out_word.is_last;
    assign o_is_empty_packet = w_out_word.is_empty_packet;
    assign o_is_abort        = w_out_word.is_abort;

endmodule

// File: dv/deframer_result_compare.sv
module deframer_result_compare #(
    parameter int PAYLOAD_CAPACITY = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_pkt_valid,
    input  logic       i_pkt_ready,
    input  logic [7:0] i_packet_id,
    input  logic [7:0] i_packet_length,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_byte_pos,
    input  logic       i_is_last,
    input  logic       i_is_empty_packet,
    input  logic       i_is_abort,
    output int         o_mismatches,
    output int         o_pending
);

    typedef enum logic [1:0] {
        HUNT_SYNC,
        TAKE_ID,
        TAKE_LENGTH,
        TAKE_PAYLOAD
    } t_parse_phase;

    t_parse_phase phase;
    logic [7:0]   sync_value;
    logic [7:0]   held_id;
    logic [7:0]   held_length;
    logic [8:0]   taken_count;

    sidlpd_pkg::t_result expected_words[$];
    int                  mismatch_count = 0;

    function automatic void restart_hunt();
        phase       = HUNT_SYNC;
        held_id     = '0;
        held_length = '0;
        taken_count = '0;
    endfunction

    // Advance the parser by one byte; return 1 when the byte yields a word.
    function automatic bit parse_rx_byte(input logic [7:0] b,
                                         output sidlpd_pkg::t_result word);
        logic [8:0] next_count;
        word = '0;
        word.packet_id     = held_id;
        word.packet_length = held_length;
        case (phase)
            HUNT_SYNC: begin
                if (b == sync_value) phase = TAKE_ID;
                return 1'b0;
            end
            TAKE_ID: begin
                held_id = b;
                phase   = TAKE_LENGTH;
                return 1'b0;
            end
            TAKE_LENGTH: begin
                held_length = b;
                taken_count = '0;
                if (b == 8'd0) begin
                    word.packet_length   = b;
                    word.is_last         = 1'b1;
                    word.is_empty_packet = 1'b1;
                    restart_hunt();
                    return 1'b1;
                end
                phase = TAKE_PAYLOAD;
                return 1'b0;
            end
            default: begin
                // drop the byte once the buffer would overflow
                if (taken_count >= PAYLOAD_CAPACITY) begin
                    word.is_last  = 1'b1;
                    word.is_abort = 1'b1;
                    restart_hunt();
                    return 1'b1;
                end
                next_count      = taken_count + 9'd1;
                word.data_byte  = b;
                word.byte_pos   = taken_count[7:0];
                word.is_last    = (next_count == {1'b0, held_length});
                taken_count     = next_count;
                if (word.is_last) restart_hunt();
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        sidlpd_pkg::t_result new_word;
        sidlpd_pkg::t_result want;
        if (!i_rst_n) begin
            expected_words.delete();
            sync_value = sidlpd_pkg::SYNC_RESET;
            restart_hunt();
        end else begin
            if (i_cfg_wr_en) sync_value = i_cfg_wr_data;
            if (i_rx_valid && i_rx_ready) begin
                if (parse_rx_byte(i_rx_byte, new_word)) expected_words.push_back(new_word);
            end
            if (i_pkt_valid && i_pkt_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word arrived with none expected");
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("packet_id", want.packet_id, i_packet_id);
                    check_field("packet_length", want.packet_length, i_packet_length);
                    check_field("data_byte", want.data_byte, i_data_byte);
                    check_field("byte_pos", want.byte_pos, i_byte_pos);
                    check_field("is_last", want.is_last, i_is_last);
                    check_field("is_empty_packet", want.is_empty_packet, i_is_empty_packet);
                    check_field("is_abort", want.is_abort, i_is_abort);
                end
            end
        end
        o_pending    <= expected_words.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// File: dv/sync_id_length_packet_deframer_unit_tb.sv
module sync_id_length_packet_deframer_unit_tb;

    localparam int CAPACITY       = 256;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 100;
    localparam int PHASE_ITEMS    = 45;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = '0;
    logic       i_rx_valid    = 1'b0;
    logic [7:0] i_rx_byte     = '0;
    logic       i_pkt_ready   = 1'b0;
    logic       o_rx_ready;
    logic       o_pkt_valid;
    logic [7:0] o_packet_id;
    logic [7:0] o_packet_length;
    logic [7:0] o_data_byte;
    logic [7:0] o_byte_pos;
    logic       o_is_last;
    logic       o_is_empty_packet;
    logic       o_is_abort;

    int mismatch_total;
    int words_pending;

    int         sender_idle_pct = 0;
    int         recv_stall_pct  = 0;
    logic       hold_start      = 1'b0;
    int         hold_left       = 0;
    int         quiet_cycles    = 0;
    logic [7:0] sync_now        = sidlpd_pkg::SYNC_RESET;
    int         phase_items     = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sync_id_length_packet_deframer_unit #(
        .PAYLOAD_CAPACITY(CAPACITY)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_pkt_valid      (o_pkt_valid),
        .i_pkt_ready      (i_pkt_ready),
        .o_packet_id      (o_packet_id),
        .o_packet_length  (o_packet_length),
        .o_data_byte      (o_data_byte),
        .o_byte_pos       (o_byte_pos),
        .o_is_last        (o_is_last),
        .o_is_empty_packet(o_is_empty_packet),
        .o_is_abort       (o_is_abort)
    );

    deframer_result_compare #(
        .PAYLOAD_CAPACITY(CAPACITY)
    ) u_compare (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_rx_valid       (i_rx_valid),
        .i_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .i_pkt_valid      (o_pkt_valid),
        .i_pkt_ready      (i_pkt_ready),
        .i_packet_id      (o_packet_id),
        .i_packet_length  (o_packet_length),
        .i_data_byte      (o_data_byte),
        .i_byte_pos       (o_byte_pos),
        .i_is_last        (o_is_last),
        .i_is_empty_packet(o_is_empty_packet),
        .i_is_abort       (o_is_abort),
        .o_mismatches     (mismatch_total),
        .o_pending        (words_pending)
    );

    // Receiver: a requested hold-off wins over the random stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pkt_ready <= 1'b0;
            hold_left   <= 0;
        end else if (hold_start) begin
            i_pkt_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            i_pkt_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_pkt_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_pkt_valid && i_pkt_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void set_idling(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin sender_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(15))
            0: return 8'h00;
            1: return 8'hFF;
            2: return sync_now;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
    endtask

    task automatic send_noise(input logic [7:0] b);
        // keep noise off the sync value so it never opens a packet
        send_byte((b == sync_now) ? ~b : b);
    endtask

    task automatic send_packet(input logic [7:0] id, input logic [7:0] len);
        send_byte(sync_now);
        send_byte(id);
        send_byte(len);
        for (int i = 0; i < len; i++) send_byte(pick_byte());
        phase_items += 3 + len;
    endtask

    task automatic send_random_packet();
        int          pick;
        logic [7:0]  len;
        pick = $urandom_range(99);
        if (pick < 15)      len = 8'd0;
        else if (pick < 85) len = 8'($urandom_range(8, 1));
        else if (pick < 97) len = 8'($urandom_range(40, 9));
        else                len = 8'($urandom_range(100, 41));
        send_packet(pick_byte(), len);
    endtask

    // Pause the sender until every expected word is back, then let the pipe settle.
    task automatic drain();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [7:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sync_now = value;
    endtask

    initial begin
        logic [7:0] next_sync;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, empty packet, sync value inside id and payload
        set_idling(0);
        send_noise(8'h00);
        send_noise(8'hFF);
        send_packet(8'h00, 8'd0);
        send_packet(8'hFF, 8'd1);
        send_byte(sync_now);
        send_byte(8'h5A);
        send_byte(8'd3);
        send_byte(8'h00);
        send_byte(sync_now);
        send_byte(8'hFF);
        send_noise(8'hA4);
        send_byte(sync_now);
        send_byte(sync_now);
        send_byte(8'd2);
        send_byte(8'h12);
        send_byte(8'h34);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph != 0) begin
                case (ph)
                    1: next_sync = 8'h00;
                    2: next_sync = 8'hFF;
                    7: next_sync = sidlpd_pkg::SYNC_RESET;
                    default: next_sync = 8'($urandom_range(255));
                endcase
                write_sync(next_sync);
            end
            set_idling(ph % 4);
            phase_items = 0;
            if (ph == 3) send_packet(pick_byte(), 8'd255);
            if (ph == 4) begin
                // hold the receiver off while a long packet streams in
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
                send_packet(pick_byte(), 8'd48);
            end
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(1) == 1) begin
                    repeat ($urandom_range(3, 1)) send_noise(8'($urandom));
                end
                send_random_packet();
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_total == 0 && words_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
